FILE: rtl/core/diq_pkg.sv
// ----------------------------------------------------------------------------
// diq_pkg
// Shared constants and the per-channel state record of the input qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package diq_pkg;

	localparam int CHANNELS  = 19;
	localparam int AC_WINDOW = 11;
	localparam int CH_W      = $clog2(CHANNELS);
	localparam int WIN_W     = $clog2(AC_WINDOW);
	localparam int DUR_W     = 8;
	// channels that own a duration byte in the three duration registers
	localparam int DUR_CHANS = 19;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_AC_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUR_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUR_MID  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUR_HIGH = 2'd3;

	// one channel's state as held in the state RAM
	typedef struct packed {
		logic             cand;
		logic             and_r;
		logic             or_r;
		logic             qual;
		logic [DUR_W-1:0] timer;
	} chan_state_t;

	localparam int STATE_W = $bits(chan_state_t);

endpackage

FILE: rtl/core/diq_if.sv
// ----------------------------------------------------------------------------
// diq_in_if / diq_out_if
// Valid/ready channels for raw scans in and qualified states out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface diq_in_if import diq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CHANNELS-1:0] raw_inputs;

	modport source (output valid, output raw_inputs, input ready);
	modport sink   (input valid, input raw_inputs, output ready);
endinterface

interface diq_out_if import diq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CHANNELS-1:0] qualified_states;

	modport source (output valid, output qualified_states, input ready);
	modport sink   (input valid, input qualified_states, output ready);
endinterface

FILE: rtl/core/diq_ram.sv
// ----------------------------------------------------------------------------
// diq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/diq_chan_update.sv
// ----------------------------------------------------------------------------
// diq_chan_update
// Next-state logic of one channel for one scan, DC debounce or AC detect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diq_chan_update import diq_pkg::*; (
	input  chan_state_t      cur,
	input  logic             raw_bit,
	input  logic             ac_mode,
	input  logic             window_end,
	input  logic [DUR_W-1:0] duration,
	output chan_state_t      nxt
);

	logic             and1;
	logic             or1;
	logic             cand_ac;
	logic [DUR_W:0]   t_inc;
	chan_state_t      dc;

	always_comb begin
		and1  = cur.and_r & raw_bit;
		or1   = cur.or_r | raw_bit;
		nxt   = cur;
		dc    = cur;
		t_inc = '0;
		cand_ac = cur.cand;

		if (ac_mode) begin
			nxt.and_r = and1;
			nxt.or_r  = or1;
			if (window_end) begin
				// toggled record means present, all-zero means absent
				cand_ac  = (!and1) ? or1 : cur.cand;
				nxt.cand = cand_ac;
				if (cand_ac != cur.qual) begin
					t_inc = {1'b0, cur.timer} + 1'b1;
					if (t_inc > {1'b0, duration}) begin
						nxt.timer = '0;
						nxt.qual  = cand_ac;
					end else begin
						nxt.timer = t_inc[DUR_W-1:0];
					end
				end else begin
					nxt.timer = '0;
				end
				nxt.and_r = 1'b1;
				nxt.or_r  = 1'b0;
			end
		end else begin
			dc.and_r = and1;
			dc.or_r  = or1;
			// raw change: restart candidate with the new level recorded
			if (cur.cand != raw_bit) begin
				dc.cand  = raw_bit;
				dc.and_r = raw_bit;
				dc.or_r  = raw_bit;
				dc.timer = '0;
			end
			nxt   = dc;
			t_inc = {1'b0, dc.timer} + 1'b1;
			if (t_inc < {1'b0, duration}) begin
				nxt.timer = t_inc[DUR_W-1:0];
			end else if (dc.and_r == dc.or_r) begin
				nxt.qual = dc.cand;
			end else begin
				nxt.cand  = raw_bit;
				nxt.and_r = 1'b1;
				nxt.or_r  = 1'b0;
				nxt.timer = '0;
			end
		end
	end

endmodule

FILE: rtl/core/digital_input_qualifier.sv
// ----------------------------------------------------------------------------
// digital_input_qualifier
// Debounce (DC) and presence (AC) qualifier for discrete input scans.
// Scans are taken one at a time: the state RAM's single read port walks
//   the channels one per cycle, and the next scan is taken at the edge
//   where the last channel's update writes back. A stalled output holds the
//   input once a finished result waits behind the full output register.
// Reset: arst_n clears control, config and window count; a valid bit per
//   channel makes never-written RAM entries read as zero, so no clear pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module digital_input_qualifier import diq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	diq_in_if.sink               scan_in,
	diq_out_if.source            state_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// configuration registers
	logic [CHANNELS-1:0] ac_mode_q;
	logic [63:0]         dur_low_q;
	logic [63:0]         dur_mid_q;
	logic [23:0]         dur_high_q;
	logic [151:0]        dur_flat;

	// scan sequencer
	logic                busy_q;
	logic [CH_W-1:0]     ch_q;
	logic [CHANNELS-1:0] raw_q;
	logic                wend_q;
	logic [WIN_W-1:0]    wc_q;
	logic [WIN_W:0]      wc_inc;
	logic                wend_now;
	logic                accept;

	// update stage
	logic                valid_s1;
	logic [CH_W-1:0]     ch_s1;
	logic                last_s1;
	logic                ent_vld_s1;
	logic [CHANNELS-1:0] ent_vld_q;
	logic [STATE_W-1:0]  ram_rdata;
	chan_state_t         cur_s1;
	chan_state_t         nxt_s1;
	logic [DUR_W-1:0]    dur_s1;

	// result assembly and output register
	logic [CHANNELS-1:0] acc_q;
	logic                done_q;
	logic                out_valid_q;
	logic [CHANNELS-1:0] out_data_q;
	logic                out_free;

	assign dur_flat = {dur_high_q, dur_mid_q, dur_low_q};

	// Configuration writes; only taken while idle by contract.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_mode_q  <= '0;
			dur_low_q  <= '0;
			dur_mid_q  <= '0;
			dur_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC_MODE:  ac_mode_q  <= cfg_wdata[CHANNELS-1:0];
				REG_DUR_LOW:  dur_low_q  <= cfg_wdata;
				REG_DUR_MID:  dur_mid_q  <= cfg_wdata;
				REG_DUR_HIGH: dur_high_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// Take a new scan once the channel walk is done and no finished result
	// waits. While the last channel is updated, the output register must be
	// free so that result moves out on the next cycle, before the new walk
	// starts to overwrite the accumulator.
	assign scan_in.ready = !busy_q && !done_q && (!valid_s1 || out_free);
	assign accept        = scan_in.valid && scan_in.ready;

	// The window end is decided per scan, independent of channel modes.
	assign wc_inc   = {1'b0, wc_q} + 1'b1;
	assign wend_now = wc_inc >= (WIN_W + 1)'(AC_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
			wc_q   <= '0;
			wend_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
			ch_q   <= '0;
			wend_q <= wend_now;
			wc_q   <= wend_now ? '0 : wc_inc[WIN_W-1:0];
		end else if (busy_q) begin
			// advance one channel per cycle; drop busy after the last read
			if (ch_q == CH_W'(CHANNELS - 1)) begin
				busy_q <= 1'b0;
				ch_q   <= '0;
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	// Hold the scan for the whole channel walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q <= scan_in.raw_inputs;
		end
	end

	// Read issue is registered alongside the RAM read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			ch_s1      <= '0;
			ent_vld_s1 <= 1'b0;
		end else begin
			valid_s1   <= busy_q;
			last_s1    <= busy_q && (ch_q == CH_W'(CHANNELS - 1));
			ch_s1      <= ch_q;
			ent_vld_s1 <= ent_vld_q[ch_q];
		end
	end

	diq_ram #(
		.WIDTH (STATE_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (ch_s1),
		.wdata (nxt_s1),
		.raddr (ch_q),
		.rdata (ram_rdata)
	);

	// A never-written entry stands for the reset state: all zero.
	assign cur_s1 = ent_vld_s1 ? chan_state_t'(ram_rdata) : '0;

	// Channels without a duration byte qualify with duration zero.
	always_comb begin
		dur_s1 = '0;
		if (32'(ch_s1) < DUR_CHANS) begin
			dur_s1 = dur_flat[{ch_s1, 3'b000} +: DUR_W];
		end
	end

	diq_chan_update u_update (
		.cur        (cur_s1),
		.raw_bit    (raw_q[ch_s1]),
		.ac_mode    (ac_mode_q[ch_s1]),
		.window_end (wend_q),
		.duration   (dur_s1),
		.nxt        (nxt_s1)
	);

	// Mark entries written once; reads of one channel never overlap its write
	// since each channel is visited once per scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (valid_s1) begin
			ent_vld_q[ch_s1] <= 1'b1;
		end
	end

	// Gather the new qualified bit of every channel.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q[ch_s1] <= nxt_s1.qual;
		end
	end

	assign out_free = !out_valid_q || state_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (state_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s1 && last_s1) begin
				done_q <= 1'b1;
			end else if (done_q && out_free) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_q && out_free) begin
			out_data_q <= acc_q;
		end
	end

	assign state_out.valid            = out_valid_q;
	assign state_out.qualified_states = out_data_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q || done_q) |-> !scan_in.ready)
		else $error("scan accepted while a channel walk or a result is in flight");

	a_walk_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && ch_q == '0))
		else $error("accepted scan did not start at channel zero");

	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && out_free) |=> (out_valid_q && !done_q))
		else $error("finished result did not move to the output register");

	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, wc_q} < (WIN_W + 1)'(AC_WINDOW)))
		else $error("window count out of range");

endmodule

FILE: tb/sv/digital_input_qualifier_tb.sv
// ----------------------------------------------------------------------------
// digital_input_qualifier_tb
// Self-checking bench for the input qualifier. Raw scans go in over the
// scan channel with random gaps, and qualified-state items come back with
// random stalls. A scoreboard keeps its own copy of the per-channel debounce
// and presence state and predicts every item. Configuration is rewritten
// between phases while the block is idle. The phases cover extreme
// durations, all-DC, all-AC and mixed modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module digital_input_qualifier_tb import diq_pkg::*; ();

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_PHASES  = 11;
	localparam int PHASE_SCANS    = 100;
	// margin left after the last item has come back
	localparam int SETTLE_CYCLES  = 30;
	localparam int CYCLE_LIMIT    = 500000;

	// how a channel's raw level evolves in the random scans
	typedef enum int {
		STYLE_HOLD,       // stable level with rare flips, lets DC timers run out
		STYLE_BOUNCE,     // random every scan, keeps restarting the DC candidate
		STYLE_SQUARE,     // toggles every scan, reads as AC present
		STYLE_LOW,        // stuck at zero, reads as AC absent
		STYLE_HIGH        // stuck at one
	} wave_style_e;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the qualifier state and checks each result item
	// ------------------------------------------------------------------------
	class qualifier_scoreboard;
		logic [CHANNELS-1:0] ac_mask;
		logic [63:0]         dur_low;
		logic [63:0]         dur_mid;
		logic [23:0]         dur_high;

		logic [CHANNELS-1:0] cand;
		logic [CHANNELS-1:0] and_rec;
		logic [CHANNELS-1:0] or_rec;
		logic [CHANNELS-1:0] qual;
		logic [DUR_W-1:0]    timer [CHANNELS];
		logic [3:0]          win_cnt;

		logic [CHANNELS-1:0] expected_states [$];
		int                  mismatches;

		function new();
			ac_mask    = '0;
			dur_low    = '0;
			dur_mid    = '0;
			dur_high   = '0;
			cand       = '0;
			and_rec    = '0;
			or_rec     = '0;
			qual       = '0;
			win_cnt    = '0;
			mismatches = 0;
			foreach (timer[i])
				timer[i] = '0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_AC_MODE:  ac_mask  = val[CHANNELS-1:0];
				REG_DUR_LOW:  dur_low  = val;
				REG_DUR_MID:  dur_mid  = val;
				REG_DUR_HIGH: dur_high = val[23:0];
				default: ;
			endcase
		endfunction

		function int duration(int ch);
			if (ch < 8)
				return int'(dur_low[8*ch +: 8]);
			else if (ch < 16)
				return int'(dur_mid[8*(ch-8) +: 8]);
			else if (ch < 19)
				return int'(dur_high[8*(ch-16) +: 8]);
			return 0;
		endfunction

		// advance the mirrored state by one accepted scan, queue the outcome
		function void note_scan(logic [CHANNELS-1:0] raw);
			bit win_end;
			int t;
			int dur;
			win_end = (int'(win_cnt) + 1 >= AC_WINDOW);
			for (int ch = 0; ch < CHANNELS; ch++) begin
				dur = duration(ch);
				if (raw[ch])
					or_rec[ch] = 1'b1;
				else
					and_rec[ch] = 1'b0;

				if (ac_mask[ch]) begin
					if (!win_end)
						continue;
					// toggled window means present, all-zero means absent
					if (!and_rec[ch])
						cand[ch] = or_rec[ch];
					if (cand[ch] != qual[ch]) begin
						t = int'(timer[ch]) + 1;
						if (t > dur) begin
							timer[ch] = '0;
							qual[ch]  = cand[ch];
						end else begin
							timer[ch] = t[DUR_W-1:0];
						end
					end else begin
						timer[ch] = '0;
					end
					and_rec[ch] = 1'b1;
					or_rec[ch]  = 1'b0;
				end else begin
					// a raw change restarts the candidate and its record
					if (cand[ch] != raw[ch]) begin
						cand[ch]    = raw[ch];
						and_rec[ch] = 1'b1;
						or_rec[ch]  = 1'b0;
						timer[ch]   = '0;
						if (raw[ch])
							or_rec[ch] = 1'b1;
						else
							and_rec[ch] = 1'b0;
					end
					t = int'(timer[ch]) + 1;
					if (t < dur) begin
						timer[ch] = t[DUR_W-1:0];
					end else if (and_rec[ch] == or_rec[ch]) begin
						qual[ch] = cand[ch];
					end else begin
						cand[ch]    = raw[ch];
						and_rec[ch] = 1'b1;
						or_rec[ch]  = 1'b0;
						timer[ch]   = '0;
					end
				end
			end
			win_cnt = win_end ? 4'd0 : win_cnt + 4'd1;
			expected_states.push_back(qual);
		endfunction

		function void check_states(logic [CHANNELS-1:0] actual);
			logic [CHANNELS-1:0] want;
			if (expected_states.size() == 0) begin
				$error("qualified_states: item with nothing expected, actual 0x%05h", actual);
				mismatches++;
				return;
			end
			want = expected_states.pop_front();
			if (actual !== want) begin
				$error("qualified_states: expected 0x%05h, actual 0x%05h", want, actual);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_states.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, block
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	diq_in_if  scan_if ();
	diq_out_if state_if ();

	digital_input_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_in   (scan_if),
		.state_out (state_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	qualifier_scoreboard sb = new();

	// per-phase switches that turn idling off for a whole phase
	bit send_calm;
	bit recv_calm;

	// random scan shaping state
	wave_style_e         chan_style [CHANNELS];
	logic [CHANNELS-1:0] chan_level;

	int unsigned cycle_count;

	always #CLK_HALF clk = ~clk;

	// Hold every input at a known value from time zero.
	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_wdata              = '0;
		scan_if.valid          = 1'b0;
		scan_if.raw_inputs     = '0;
		state_if.ready         = 1'b0;
		send_calm              = 1'b0;
		recv_calm              = 1'b0;
		chan_level             = '0;
		foreach (chan_style[i])
			chan_style[i] = STYLE_HOLD;
	end

	// Watchdog: drop the run if it stalls far beyond the slowest correct run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("digital_input_qualifier verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result side: draw a stall per item, then take and check it
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				state_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			state_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!state_if.valid);
			sb.check_states(state_if.qualified_states);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks; each starts and ends at a falling edge
	// ------------------------------------------------------------------------
	task automatic send_scan(input logic [CHANNELS-1:0] raw);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			scan_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		scan_if.valid      <= 1'b1;
		scan_if.raw_inputs <= raw;
		do
			@(posedge clk);
		while (!scan_if.ready);
		sb.note_scan(raw);
		@(negedge clk);
	endtask

	// Drop valid and wait for every outstanding item to come back.
	task automatic drain();
		scan_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write one register; only called while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		sb.configure(idx, val);
	endtask

	task automatic write_all(input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] mid, input logic [CFG_W-1:0] hi);
		write_reg(REG_AC_MODE, mode);
		write_reg(REG_DUR_LOW, lo);
		write_reg(REG_DUR_MID, mid);
		write_reg(REG_DUR_HIGH, hi);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Random content helpers
	// ------------------------------------------------------------------------

	// Mostly short durations so qualification happens within a phase;
	// now and then the full 255 to park timers high for a later phase.
	function automatic logic [7:0] pick_duration();
		int r;
		r = $urandom_range(0, 15);
		if (r <= 2)
			return 8'd0;
		else if (r <= 9)
			return 8'($urandom_range(1, 4));
		else if (r <= 13)
			return 8'($urandom_range(5, 20));
		else if (r == 14)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [CFG_W-1:0] pick_duration_reg();
		logic [CFG_W-1:0] v;
		for (int b = 0; b < 8; b++)
			v[8*b +: 8] = pick_duration();
		return v;
	endfunction

	// Bits above the channel count ride along to check they are ignored.
	function automatic logic [CFG_W-1:0] pick_mode_mask();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Next raw scan: each channel follows its wave style, which is redrawn
	// now and then; one scan in eight is plain noise.
	function automatic logic [CHANNELS-1:0] next_scan();
		if ($urandom_range(0, 7) == 0)
			return CHANNELS'($urandom);
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if ($urandom_range(0, 29) == 0)
				chan_style[ch] = wave_style_e'($urandom_range(0, 4));
			case (chan_style[ch])
				STYLE_HOLD:   if ($urandom_range(0, 39) == 0) chan_level[ch] = ~chan_level[ch];
				STYLE_BOUNCE: chan_level[ch] = 1'($urandom_range(0, 1));
				STYLE_SQUARE: chan_level[ch] = ~chan_level[ch];
				STYLE_LOW:    chan_level[ch] = 1'b0;
				STYLE_HIGH:   chan_level[ch] = 1'b1;
				default: ;
			endcase
		end
		return chan_level;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [CHANNELS-1:0] dc_scans [8];
		dc_scans = '{19'h00000, 19'h7FFFF, 19'h7FFFF, 19'h00000,
			19'h55555, 19'h2AAAA, 19'h00001, 19'h40000};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset configuration: all DC, zero durations, so a stable record
		// qualifies on the same scan. Walk the field extremes and patterns.
		foreach (dc_scans[i])
			send_scan(dc_scans[i]);
		drain();

		// All AC with zero durations; upper mask bits set and ignored. The
		// window carries over from the DC scans, so the first window end
		// lands inside the toggling run (present), the next one after a full
		// window of zeros (absent).
		write_all('1, '0, '0, '0);
		for (int i = 0; i < 4; i++)
			send_scan((i % 2 == 0) ? 19'h7FFFF : 19'h00000);
		for (int i = 0; i < 12; i++)
			send_scan(19'h00000);
		drain();

		// All DC at the longest duration; timers start climbing and carry their
		// values into the next phase.
		write_all('0, '1, '1, '1);
		send_scan(19'h7FFFF);
		drain();

		// Random phases: fresh modes and durations each time, mode changes
		// land mid-window, and some phases run with no idling at all.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_all(pick_mode_mask(), pick_duration_reg(), pick_duration_reg(),
				{$urandom, $urandom});
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_SCANS; i++)
				send_scan(next_scan());
			drain();
		end

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("digital_input_qualifier verification clean");
		end else begin
			$display("digital_input_qualifier verification failed");
		end
		$finish;
	end

endmodule
